FILE: rtl/core/gcp_pkg.sv
// Shared constants, sideband types and arithmetic helpers for the
// gaussian collision probability core. No dependencies.
`default_nettype none

package gcp_pkg;

  // Field and register widths
  localparam int POS_W    = 28;
  localparam int SIG_W    = 26;
  localparam int RAD_W    = 24;
  localparam int PROB_W   = 32;
  localparam int SQD_W    = 57;   // one squared position difference
  localparam int SQS_W    = 52;   // one squared sigma
  localparam int DIST_W   = 58;   // sum of three squared differences
  localparam int VAR_W    = 55;   // sum of six squared sigmas
  localparam int REM_W    = VAR_W;
  localparam int RSQ_W    = 2 * RAD_W;
  localparam int R2_W     = RSQ_W + 2;
  localparam int R2_LO_W  = R2_W / 2;
  localparam int R2_HI_W  = R2_W - R2_LO_W;
  localparam int EXP_W    = 31;   // Q1.30, at most 1.0
  localparam int EXP_FRAC_W = 30;
  localparam int PROD_W   = R2_HI_W + EXP_W + R2_LO_W;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(2560);

  // Exponent x = r^2/(2 s^2) in Q6.16
  localparam int XI_W     = 6;
  localparam int XF_W     = 16;
  localparam int QUO1_W   = XI_W + XF_W;
  localparam int DIV1_STEPS = QUO1_W;
  localparam int DIV2_STEPS = PROB_W;

  // Exponential table
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_ADR_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int EXP_M1_W  = 29;
  localparam logic [EXP_M1_W-1:0] EXP_M1_Q30 = EXP_M1_W'(395007542);
  // After this many multiplications by exp(-1) any value has reached zero
  localparam int EXP_STEPS = 22;

  localparam logic [PROB_W-1:0] ONE_Q31 = PROB_W'(64'h8000_0000);

  typedef struct packed {
    logic             degenerate;
    logic             far;
    logic [VAR_W-1:0] s;
  } gcp_side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic             q;
  } div_res_t;

  // One restoring division step: bring down a bit, subtract when it fits
  function automatic div_res_t div_step(input logic [REM_W-1:0] rem, input logic din,
                                        input logic [VAR_W-1:0] dvs);
    logic [REM_W:0] sh;
    logic [REM_W:0] dif;
    div_res_t       r;
    sh  = {rem, din};
    dif = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      r.rem = dif[REM_W-1:0];
      r.q   = 1'b1;
    end else begin
      r.rem = sh[REM_W-1:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

  // Divide by a small series index, elaboration only
  function automatic longint unsigned div_small(input longint unsigned v, input int unsigned j);
    longint unsigned r;
    case (j)
      1:       r = v;
      2:       r = v >> 1;
      3:       r = v / 64'd3;
      4:       r = v >> 2;
      5:       r = v / 64'd5;
      6:       r = v / 64'd6;
      7:       r = v / 64'd7;
      8:       r = v >> 3;
      9:       r = v / 64'd9;
      10:      r = v / 64'd10;
      11:      r = v / 64'd11;
      12:      r = v / 64'd12;
      13:      r = v / 64'd13;
      14:      r = v / 64'd14;
      15:      r = v / 64'd15;
      16:      r = v >> 4;
      default: r = v;
    endcase
    return r;
  endfunction

  // Table entry: Q1.30 of exp(-k/N) by a 17-term series, clamped to [0, 1]
  function automatic logic [EXP_W-1:0] rom_entry(input int unsigned k);
    longint unsigned u;
    longint unsigned t;
    longint          acc;
    logic [EXP_W-1:0] r;
    u = (64'(k) << 30) + 64'(EXP_TABLE_DEPTH / 2);
    u = u / 64'(EXP_TABLE_DEPTH);
    t = 64'd1 << 30;
    acc = 64'sd1 << 30;
    for (int unsigned j = 1; j <= 16; j++) begin
      t = div_small((t * u) >> 30, j);
      if (j[0]) acc = acc - longint'(t);
      else      acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    r = acc[EXP_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gcp_exp.sv
// Pipelined exp(-x) for x in Q6.16: table lookup, linear interpolation and a
// chain of exp(-1) multiplications. Depends on gcp_pkg.
`default_nettype none

module gcp_exp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic [gcp_pkg::QUO1_W-1:0]     in_quo,
  input  gcp_pkg::gcp_side_t             in_side,
  output logic                           out_valid,
  output logic [gcp_pkg::EXP_W-1:0]      out_e,
  output gcp_pkg::gcp_side_t             out_side
);

  localparam int IDX_W = gcp_pkg::XF_W + gcp_pkg::EXP_IDX_W;
  localparam int EW    = gcp_pkg::EXP_W;
  localparam int XW    = gcp_pkg::XI_W;
  localparam int FW    = gcp_pkg::XF_W;
  localparam int DPW   = EW + FW;
  localparam int MPW   = EW + gcp_pkg::EXP_M1_W;

  // Constant table of exp(-k/N), one entry beyond the last index
  logic [EW-1:0] exp_rom [gcp_pkg::EXP_TABLE_DEPTH + 1];
  for (genvar g = 0; g <= gcp_pkg::EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_rom[g] = gcp_pkg::rom_entry(g);
  end

  // Table index and interpolation weight
  logic [IDX_W-1:0]               idx;
  logic [gcp_pkg::EXP_ADR_W-1:0]  ka;
  logic [gcp_pkg::EXP_ADR_W-1:0]  kb;
  logic [EW-1:0]                  t0;
  logic [EW-1:0]                  t1;
  logic [EW-1:0]                  tdiff;
  always_comb begin
    idx   = IDX_W'(in_quo[FW-1:0]) * IDX_W'(gcp_pkg::EXP_TABLE_DEPTH);
    ka    = gcp_pkg::EXP_ADR_W'(idx[FW +: gcp_pkg::EXP_IDX_W]);
    kb    = ka + 1'b1;
    t0    = exp_rom[ka];
    t1    = exp_rom[kb];
    tdiff = (t0 > t1) ? (t0 - t1) : '0;
  end

  logic                 e1_vld;
  logic [EW-1:0]        e1_t0;
  logic [EW-1:0]        e1_diff;
  logic [FW-1:0]        e1_w;
  logic [XW-1:0]        e1_xi;
  gcp_pkg::gcp_side_t   e1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld <= 1'b0;
    end else if (adv) begin
      e1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_t0   <= t0;
      e1_diff <= tdiff;
      e1_w    <= idx[FW-1:0];
      e1_xi   <= in_quo[gcp_pkg::QUO1_W-1 -: XW];
      e1_side <= in_side;
    end
  end

  // Interpolate between neighbouring entries
  logic [DPW-1:0] dprod;
  assign dprod = DPW'(e1_diff) * DPW'(e1_w);

  logic               mul_vld  [gcp_pkg::EXP_STEPS + 1];
  logic [EW-1:0]      mul_e    [gcp_pkg::EXP_STEPS + 1];
  logic [XW-1:0]      mul_xi   [gcp_pkg::EXP_STEPS + 1];
  gcp_pkg::gcp_side_t mul_side [gcp_pkg::EXP_STEPS + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld[0] <= 1'b0;
    end else if (adv) begin
      mul_vld[0] <= e1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_e[0]    <= e1_t0 - dprod[DPW-1:FW];
      mul_xi[0]   <= e1_xi;
      mul_side[0] <= e1_side;
    end
  end

  // Apply exp(-1) once per integer unit, at most EXP_STEPS times, one multiply per stage
  for (genvar j = 0; j < gcp_pkg::EXP_STEPS; j++) begin : g_mul
    logic [MPW-1:0] mp;
    assign mp = MPW'(mul_e[j]) * MPW'(gcp_pkg::EXP_M1_Q30);

    always_ff @(posedge clk) begin
      if (rst) begin
        mul_vld[j+1] <= 1'b0;
      end else if (adv) begin
        mul_vld[j+1] <= mul_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (mul_xi[j] > XW'(j)) begin
          mul_e[j+1] <= EW'(mp[MPW-1:gcp_pkg::EXP_FRAC_W]);
        end else begin
          mul_e[j+1] <= mul_e[j];
        end
        mul_xi[j+1]   <= mul_xi[j];
        mul_side[j+1] <= mul_side[j];
      end
    end
  end

  assign out_valid = mul_vld[gcp_pkg::EXP_STEPS];
  assign out_e     = mul_e[gcp_pkg::EXP_STEPS];
  assign out_side  = mul_side[gcp_pkg::EXP_STEPS];

endmodule

`default_nettype wire

FILE: rtl/core/gaussian_collision_probability_core.sv
// Top level of the gaussian collision probability core: distance and variance
// sums, two pipelined dividers and the final scaling. Depends on gcp_pkg, gcp_exp.
`default_nettype none

// One conjunction enters per clock cycle while result_stall does not hold
// the pipeline; each result passes the two bit-per-stage restoring dividers
// (22 and 32 stages) and the 22-stage exp(-1) multiply chain. The whole
// pipeline holds while a finished beat waits on result_stall, so pair_stall
// follows result_stall in that case. The radius register is always ready;
// 3 R^2 is derived from it through the rsq and r2 registers and is sampled
// when a beat reaches the scaling stage, so write the radius only while
// no beat is in flight.
module gaussian_collision_probability_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gcp_pkg::RAD_W-1:0]     cfg_data,
  input  logic                          pair_valid,
  output logic                          pair_stall,
  input  logic signed [gcp_pkg::POS_W-1:0] pos_a_x,
  input  logic signed [gcp_pkg::POS_W-1:0] pos_a_y,
  input  logic signed [gcp_pkg::POS_W-1:0] pos_a_z,
  input  logic signed [gcp_pkg::POS_W-1:0] pos_b_x,
  input  logic signed [gcp_pkg::POS_W-1:0] pos_b_y,
  input  logic signed [gcp_pkg::POS_W-1:0] pos_b_z,
  input  logic [gcp_pkg::SIG_W-1:0]     sigma_a_x,
  input  logic [gcp_pkg::SIG_W-1:0]     sigma_a_y,
  input  logic [gcp_pkg::SIG_W-1:0]     sigma_a_z,
  input  logic [gcp_pkg::SIG_W-1:0]     sigma_b_x,
  input  logic [gcp_pkg::SIG_W-1:0]     sigma_b_y,
  input  logic [gcp_pkg::SIG_W-1:0]     sigma_b_z,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [gcp_pkg::PROB_W-1:0]    probability,
  output logic                          saturated,
  output logic                          degenerate
);

  localparam int PW   = gcp_pkg::POS_W;
  localparam int SW   = gcp_pkg::SIG_W;
  localparam int DW   = gcp_pkg::DIST_W;
  localparam int VW   = gcp_pkg::VAR_W;
  localparam int RW   = gcp_pkg::REM_W;
  localparam int FARW = DW + 11;
  localparam int MW   = gcp_pkg::PROD_W;
  localparam int LIMW = VW + gcp_pkg::PROB_W - 1;
  localparam int QW   = gcp_pkg::PROB_W;

  logic adv;
  assign adv        = !result_valid || !result_stall;
  assign pair_stall = !adv;
  assign cfg_ready  = 1'b1;

  // Radius register and the derived 3 R^2
  logic [gcp_pkg::RAD_W-1:0] radius;
  logic [gcp_pkg::RSQ_W-1:0] rsq;
  logic [gcp_pkg::R2_W-1:0]  r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcp_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    rsq <= gcp_pkg::RSQ_W'(radius) * gcp_pkg::RSQ_W'(radius);
    r2  <= {2'b00, rsq} + {1'b0, rsq, 1'b0};
  end

  // Stage 1: per-axis squares
  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];
  logic [SW-1:0]        sg [6];
  logic signed [PW:0]   dd [3];
  logic signed [2*PW+1:0] dsq [3];
  always_comb begin
    pa[0] = pos_a_x; pa[1] = pos_a_y; pa[2] = pos_a_z;
    pb[0] = pos_b_x; pb[1] = pos_b_y; pb[2] = pos_b_z;
    sg[0] = sigma_a_x; sg[1] = sigma_a_y; sg[2] = sigma_a_z;
    sg[3] = sigma_b_x; sg[4] = sigma_b_y; sg[5] = sigma_b_z;
    for (int i = 0; i < 3; i++) begin
      dd[i]  = {pa[i][PW-1], pa[i]} - {pb[i][PW-1], pb[i]};
      dsq[i] = dd[i] * dd[i];
    end
  end

  logic                      s1_vld;
  logic [gcp_pkg::SQD_W-1:0] s1_sqd [3];
  logic [gcp_pkg::SQS_W-1:0] s1_sqs [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_sqd[i] <= dsq[i][gcp_pkg::SQD_W-1:0];
      end
      for (int i = 0; i < 6; i++) begin
        s1_sqs[i] <= gcp_pkg::SQS_W'(sg[i]) * gcp_pkg::SQS_W'(sg[i]);
      end
    end
  end

  // Stage 2: squared miss distance and variance sum
  logic          s2_vld;
  logic [DW-1:0] s2_d;
  logic [VW-1:0] s2_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_d <= DW'(s1_sqd[0]) + DW'(s1_sqd[1]) + DW'(s1_sqd[2]);
      s2_s <= VW'(s1_sqs[0]) + VW'(s1_sqs[1]) + VW'(s1_sqs[2])
            + VW'(s1_sqs[3]) + VW'(s1_sqs[4]) + VW'(s1_sqs[5]);
    end
  end

  // Stage 3: far-miss test and first partial remainder of 98304 D / S
  logic [FARW-1:0] d1536;
  logic [46:0]     d3;
  assign d1536 = {1'b0, s2_d, 10'd0} + {2'b00, s2_d, 9'd0};
  assign d3    = {1'b0, s2_d[44:0], 1'b0} + {2'b00, s2_d[44:0]};

  logic               dv1_vld  [gcp_pkg::DIV1_STEPS + 1];
  logic [RW-1:0]      dv1_rem  [gcp_pkg::DIV1_STEPS + 1];
  logic [gcp_pkg::QUO1_W-1:0] dv1_quo [gcp_pkg::DIV1_STEPS + 1];
  gcp_pkg::gcp_side_t dv1_side [gcp_pkg::DIV1_STEPS + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv1_vld[0] <= 1'b0;
    end else if (adv) begin
      dv1_vld[0] <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv1_rem[0]             <= {d3[45:0], 9'd0};
      dv1_quo[0]             <= '0;
      dv1_side[0].s          <= s2_s;
      dv1_side[0].degenerate <= (s2_s == '0);
      dv1_side[0].far        <= (d1536 >= FARW'(s2_s));
    end
  end

  // Exponent divider: one quotient bit per stage, dividend bits below are zero
  for (genvar i = 0; i < gcp_pkg::DIV1_STEPS; i++) begin : g_dv1
    gcp_pkg::div_res_t res;
    assign res = gcp_pkg::div_step(dv1_rem[i], 1'b0, dv1_side[i].s);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv1_vld[i+1] <= 1'b0;
      end else if (adv) begin
        dv1_vld[i+1] <= dv1_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv1_rem[i+1]  <= res.rem;
        dv1_quo[i+1]  <= {dv1_quo[i][gcp_pkg::QUO1_W-2:0], res.q};
        dv1_side[i+1] <= dv1_side[i];
      end
    end
  end

  // Exponential
  logic                          ex_vld;
  logic [gcp_pkg::EXP_W-1:0]     ex_e;
  gcp_pkg::gcp_side_t            ex_side;

  gcp_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (dv1_vld[gcp_pkg::DIV1_STEPS]),
    .in_quo    (dv1_quo[gcp_pkg::DIV1_STEPS]),
    .in_side   (dv1_side[gcp_pkg::DIV1_STEPS]),
    .out_valid (ex_vld),
    .out_e     (ex_e),
    .out_side  (ex_side)
  );

  // F1: split product 3 R^2 * E
  logic [gcp_pkg::EXP_W-1:0] e_eff;
  assign e_eff = ex_side.far ? '0 : ex_e;

  localparam int PHW = gcp_pkg::R2_HI_W + gcp_pkg::EXP_W;
  localparam int PLW = gcp_pkg::R2_LO_W + gcp_pkg::EXP_W;

  logic               f1_vld;
  logic [PHW-1:0]     f1_ph;
  logic [PLW-1:0]     f1_pl;
  gcp_pkg::gcp_side_t f1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
    end else if (adv) begin
      f1_vld <= ex_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_ph   <= PHW'(r2[gcp_pkg::R2_W-1 -: gcp_pkg::R2_HI_W]) * PHW'(e_eff);
      f1_pl   <= PLW'(r2[gcp_pkg::R2_LO_W-1:0]) * PLW'(e_eff);
      f1_side <= ex_side;
    end
  end

  // F2: full product, clamp test, first remainder of the scaling divide
  logic [MW-1:0]   prod;
  logic [LIMW-1:0] lim;
  assign prod = {f1_ph, gcp_pkg::R2_LO_W'(0)} + MW'(f1_pl);
  assign lim  = {f1_side.s, 31'd0} + LIMW'(f1_side.s);

  logic          dv2_vld [gcp_pkg::DIV2_STEPS + 1];
  logic [RW-1:0] dv2_rem [gcp_pkg::DIV2_STEPS + 1];
  logic [QW-1:0] dv2_qm  [gcp_pkg::DIV2_STEPS + 1];
  logic [VW-1:0] dv2_s   [gcp_pkg::DIV2_STEPS + 1];
  logic          dv2_sat [gcp_pkg::DIV2_STEPS + 1];
  logic          dv2_deg [gcp_pkg::DIV2_STEPS + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv2_vld[0] <= 1'b0;
    end else if (adv) begin
      dv2_vld[0] <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv2_rem[0] <= RW'(prod[MW-1:QW]);
      dv2_qm[0]  <= prod[QW-1:0];
      dv2_s[0]   <= f1_side.s;
      dv2_sat[0] <= !f1_side.degenerate && (LIMW'(prod) >= lim);
      dv2_deg[0] <= f1_side.degenerate;
    end
  end

  // Scaling divider: dividend bits shift out of qm as quotient bits shift in
  for (genvar i = 0; i < gcp_pkg::DIV2_STEPS; i++) begin : g_dv2
    gcp_pkg::div_res_t res;
    assign res = gcp_pkg::div_step(dv2_rem[i], dv2_qm[i][QW-1], dv2_s[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv2_vld[i+1] <= 1'b0;
      end else if (adv) begin
        dv2_vld[i+1] <= dv2_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv2_rem[i+1] <= res.rem;
        dv2_qm[i+1]  <= {dv2_qm[i][QW-2:0], res.q};
        dv2_s[i+1]   <= dv2_s[i];
        dv2_sat[i+1] <= dv2_sat[i];
        dv2_deg[i+1] <= dv2_deg[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv2_vld[gcp_pkg::DIV2_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dv2_deg[gcp_pkg::DIV2_STEPS]) begin
        probability <= '0;
      end else if (dv2_sat[gcp_pkg::DIV2_STEPS]) begin
        probability <= gcp_pkg::ONE_Q31;
      end else begin
        probability <= dv2_qm[gcp_pkg::DIV2_STEPS];
      end
      saturated  <= dv2_sat[gcp_pkg::DIV2_STEPS];
      degenerate <= dv2_deg[gcp_pkg::DIV2_STEPS];
    end
  end

`ifndef SYNTH
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate |-> probability == '0 && !saturated)
    else $error("degenerate beat with non-zero probability or clamp flag");

  a_sat_one: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> probability == gcp_pkg::ONE_Q31)
    else $error("clamped beat not at 1.0");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> probability <= gcp_pkg::ONE_Q31)
    else $error("probability above 1.0");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pair_stall |-> result_valid && result_stall)
    else $error("input held without a waiting result beat");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result beat straight after reset");
`endif

endmodule

`default_nettype wire
